// ===== rtl/bqc_pkg.sv =====
`default_nettype none
package bqc_pkg;

  localparam int MAX_SECTIONS = 3;
  localparam int SEC_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int SAMPLE_W = 24;
  localparam int COEF_W = 24;
  localparam int GAIN_W = 23;
  localparam int CNT_W = 2;
  localparam int DELAY_W = 32;
  localparam int OPA_W = 35;
  localparam int PROD_W = OPA_W + COEF_W;
  localparam int ACC_W = PROD_W + 1;
  localparam int FRAC = 22;
  localparam int RND_W = ACC_W - FRAC;
  localparam int STEP_W = $clog2(COEF_W);

  localparam logic [2:0] CFG_B0 = 3'd0;
  localparam logic [2:0] CFG_B1 = 3'd1;
  localparam logic [2:0] CFG_B2 = 3'd2;
  localparam logic [2:0] CFG_A1 = 3'd3;
  localparam logic [2:0] CFG_A2 = 3'd4;
  localparam logic [2:0] CFG_GAIN = 3'd5;
  localparam logic [2:0] CFG_COUNT = 3'd6;

  typedef enum logic [2:0] {
    OP_A1D1 = 3'd0,
    OP_A2D2 = 3'd1,
    OP_B0W  = 3'd2,
    OP_B1D1 = 3'd3,
    OP_B2D2 = 3'd4,
    OP_GAIN = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  typedef struct packed {
    logic                     start;
    logic signed [OPA_W-1:0]  a;
    logic signed [COEF_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

  function automatic logic signed [RND_W-1:0] rnd22(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    s = v + ACC_W'(64'sd1 <<< (FRAC - 1));
    return s[ACC_W-1:FRAC];
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat32(input logic signed [RND_W-1:0] r);
    if (r[RND_W-1:DELAY_W-1] == {(RND_W-DELAY_W+1){r[DELAY_W-1]}}) begin
      return r[DELAY_W-1:0];
    end
    return r[RND_W-1] ? {1'b1, {(DELAY_W-1){1'b0}}} : {1'b0, {(DELAY_W-1){1'b1}}};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [RND_W-1:0] r);
    if (r[RND_W-1:SAMPLE_W-1] == {(RND_W-SAMPLE_W+1){r[SAMPLE_W-1]}}) begin
      return r[SAMPLE_W-1:0];
    end
    return r[RND_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bqc_mul.sv =====
`default_nettype none
module bqc_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bqc_pkg::mul_req_t req,
  output bqc_pkg::mul_rsp_t      rsp
);

  logic                                  busy_r, busy_nxt;
  logic                                  done_r, done_nxt;
  logic [bqc_pkg::STEP_W-1:0]            cnt_r, cnt_nxt;
  logic signed [bqc_pkg::PROD_W-1:0]     mcand_r, mcand_nxt;
  logic [bqc_pkg::COEF_W-1:0]            mplier_r, mplier_nxt;
  logic signed [bqc_pkg::PROD_W-1:0]     prod_r, prod_nxt;
  logic                                  last;

  assign last = (cnt_r == bqc_pkg::STEP_W'(bqc_pkg::COEF_W - 1));

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    mcand_nxt = mcand_r;
    mplier_nxt = mplier_r;
    prod_nxt = prod_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      mcand_nxt = {{(bqc_pkg::PROD_W-bqc_pkg::OPA_W){req.a[bqc_pkg::OPA_W-1]}}, req.a};
      mplier_nxt = req.b;
      prod_nxt = '0;
    end else if (busy_r) begin
      // sign bit of the multiplier carries negative weight
      if (mplier_r[0]) begin
        prod_nxt = last ? prod_r - mcand_r : prod_r + mcand_r;
      end
      mcand_nxt = mcand_r <<< 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    mplier_r <= mplier_nxt;
    prod_r <= prod_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

endmodule
`default_nettype wire

// ===== rtl/biquad_cascade_filter_core.sv =====
// Cascade of 1 to 3 direct-form-II biquad sections sharing one coefficient set
// (Q2.22) and one section gain (Q1.22); output saturated to 24 bits. All
// multiplies run through one bit-serial shift-add multiplier, one multiplier
// bit per cycle. Each section needs six multiplies, issued one after another;
// one item is in work at a time, while a finished result may wait in the
// output register. Write configuration only while idle.
`default_nettype none
module biquad_cascade_filter_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic signed [bqc_pkg::SAMPLE_W-1:0] in_sample_in,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic signed [bqc_pkg::SAMPLE_W-1:0] out_sample_out,
  input  wire logic                                cfg_wr_en,
  input  wire logic [2:0]                          cfg_index,
  input  wire logic [bqc_pkg::COEF_W-1:0]          cfg_data
);

  bqc_pkg::state_t                          state_r, state_nxt;
  bqc_pkg::op_t                             op_r, op_nxt;
  logic [bqc_pkg::SEC_W-1:0]                sec_r, sec_nxt, sec_last;
  logic signed [bqc_pkg::COEF_W-1:0]        b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [bqc_pkg::GAIN_W-1:0]               gain_r;
  logic [bqc_pkg::CNT_W-1:0]                count_r;
  logic signed [bqc_pkg::SAMPLE_W-1:0]      x_r, x_nxt;
  logic signed [bqc_pkg::ACC_W-1:0]         acc_r, acc_nxt, prod_ext, x_ext;
  logic signed [bqc_pkg::DELAY_W-1:0]       w_r, w_nxt;
  logic signed [bqc_pkg::OPA_W-1:0]         accr_r, accr_nxt;
  logic signed [bqc_pkg::DELAY_W-1:0]       d1_r [bqc_pkg::MAX_SECTIONS];
  logic signed [bqc_pkg::DELAY_W-1:0]       d2_r [bqc_pkg::MAX_SECTIONS];
  logic signed [bqc_pkg::DELAY_W-1:0]       d1_cur, d2_cur;
  logic signed [bqc_pkg::RND_W-1:0]         rnd_v;
  logic                                     d_we;
  logic                                     out_valid_r;
  logic signed [bqc_pkg::SAMPLE_W-1:0]      out_sample_r;
  logic                                     out_load;
  bqc_pkg::mul_req_t                        mreq;
  bqc_pkg::mul_rsp_t                        mrsp;

  bqc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign d1_cur = d1_r[sec_r];
  assign d2_cur = d2_r[sec_r];
  assign prod_ext = {mrsp.prod[bqc_pkg::PROD_W-1], mrsp.prod};
  assign x_ext = {{(bqc_pkg::ACC_W-bqc_pkg::SAMPLE_W){x_r[bqc_pkg::SAMPLE_W-1]}}, x_r};

  always_comb begin
    if (count_r == '0) begin
      sec_last = '0;
    end else if (32'(count_r) > bqc_pkg::MAX_SECTIONS) begin
      sec_last = bqc_pkg::SEC_W'(bqc_pkg::MAX_SECTIONS - 1);
    end else begin
      sec_last = bqc_pkg::SEC_W'(count_r - 1'b1);
    end
  end

  always_comb begin
    mreq.start = (state_r == bqc_pkg::S_ISSUE);
    unique case (op_r)
      bqc_pkg::OP_A1D1: begin
        mreq.a = bqc_pkg::OPA_W'(d1_cur);
        mreq.b = a1_r;
      end
      bqc_pkg::OP_A2D2: begin
        mreq.a = bqc_pkg::OPA_W'(d2_cur);
        mreq.b = a2_r;
      end
      bqc_pkg::OP_B0W: begin
        mreq.a = bqc_pkg::OPA_W'(w_r);
        mreq.b = b0_r;
      end
      bqc_pkg::OP_B1D1: begin
        mreq.a = bqc_pkg::OPA_W'(d1_cur);
        mreq.b = b1_r;
      end
      bqc_pkg::OP_B2D2: begin
        mreq.a = bqc_pkg::OPA_W'(d2_cur);
        mreq.b = b2_r;
      end
      bqc_pkg::OP_GAIN: begin
        mreq.a = accr_r;
        mreq.b = {1'b0, gain_r};
      end
      default: begin
        mreq.a = '0;
        mreq.b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    sec_nxt = sec_r;
    x_nxt = x_r;
    acc_nxt = acc_r;
    w_nxt = w_r;
    accr_nxt = accr_r;
    d_we = 1'b0;
    out_load = 1'b0;
    rnd_v = '0;
    unique case (state_r)
      bqc_pkg::S_IDLE: begin
        if (in_valid) begin
          x_nxt = in_sample_in;
          op_nxt = bqc_pkg::OP_A1D1;
          sec_nxt = '0;
          state_nxt = bqc_pkg::S_ISSUE;
        end
      end
      bqc_pkg::S_ISSUE: begin
        state_nxt = bqc_pkg::S_WAIT;
      end
      bqc_pkg::S_WAIT: begin
        if (mrsp.done) begin
          state_nxt = bqc_pkg::S_ISSUE;
          op_nxt = bqc_pkg::op_t'(op_r + 3'd1);
          unique case (op_r)
            bqc_pkg::OP_A1D1: acc_nxt = (x_ext <<< bqc_pkg::FRAC) - prod_ext;
            bqc_pkg::OP_A2D2: begin
              rnd_v = bqc_pkg::rnd22(acc_r - prod_ext);
              w_nxt = bqc_pkg::sat32(rnd_v);
            end
            bqc_pkg::OP_B0W: acc_nxt = prod_ext;
            bqc_pkg::OP_B1D1: acc_nxt = acc_r + prod_ext;
            bqc_pkg::OP_B2D2: begin
              rnd_v = bqc_pkg::rnd22(acc_r + prod_ext);
              accr_nxt = rnd_v[bqc_pkg::OPA_W-1:0];
            end
            bqc_pkg::OP_GAIN: begin
              rnd_v = bqc_pkg::rnd22(prod_ext);
              x_nxt = bqc_pkg::sat24(rnd_v);
              d_we = 1'b1;
              op_nxt = bqc_pkg::OP_A1D1;
              if (sec_r == sec_last) begin
                state_nxt = bqc_pkg::S_DONE;
              end else begin
                sec_nxt = sec_r + 1'b1;
              end
            end
            default: state_nxt = bqc_pkg::S_IDLE;
          endcase
        end
      end
      bqc_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          state_nxt = bqc_pkg::S_IDLE;
        end
      end
      default: state_nxt = bqc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bqc_pkg::S_IDLE;
      op_r <= bqc_pkg::OP_A1D1;
      sec_r <= '0;
      out_valid_r <= 1'b0;
      b0_r <= '0;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
      gain_r <= bqc_pkg::GAIN_W'(1 << bqc_pkg::FRAC);
      count_r <= bqc_pkg::CNT_W'(1);
      for (int i = 0; i < bqc_pkg::MAX_SECTIONS; i++) begin
        d1_r[i] <= '0;
        d2_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      sec_r <= sec_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (d_we) begin
        d1_r[sec_r] <= w_r;
        d2_r[sec_r] <= d1_cur;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          bqc_pkg::CFG_B0: b0_r <= cfg_data;
          bqc_pkg::CFG_B1: b1_r <= cfg_data;
          bqc_pkg::CFG_B2: b2_r <= cfg_data;
          bqc_pkg::CFG_A1: a1_r <= cfg_data;
          bqc_pkg::CFG_A2: a2_r <= cfg_data;
          bqc_pkg::CFG_GAIN: gain_r <= cfg_data[bqc_pkg::GAIN_W-1:0];
          bqc_pkg::CFG_COUNT: count_r <= cfg_data[bqc_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
    end
    x_r <= x_nxt;
    acc_r <= acc_nxt;
    w_r <= w_nxt;
    accr_r <= accr_nxt;
    if (out_load) begin
      out_sample_r <= x_r;
    end
  end

  assign in_ready = (state_r == bqc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule
`default_nettype wire

// ===== rtl/bqc_checker.sv =====
`default_nettype none
module bqc_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [bqc_pkg::SAMPLE_W-1:0] out_sample_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out))
    else $error("result dropped or changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too soon after an item");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind biquad_cascade_filter_core bqc_checker u_bqc_checker (.*);
`default_nettype wire

// ===== tb/biquad_cascade_filter_core_tb.sv =====
`default_nettype none
module biquad_cascade_filter_core_tb;
  import bqc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] CFG_NONE = 3'd7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic out_valid;
  logic out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic cfg_wr_en;
  logic [2:0] cfg_index;
  logic [COEF_W-1:0] cfg_data;

  biquad_cascade_filter_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample_out(out_sample_out),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  longint filt_b0, filt_b1, filt_b2, filt_a1, filt_a2;
  longint filt_gain;
  int unsigned filt_count;
  longint filt_delay [2*MAX_SECTIONS];

  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int fail_count;
  int idle_cycles;
  int stall_left;
  bit sender_idles;
  bit receiver_idles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint round_q22(longint v);
    return (v + (64'sd1 <<< 21)) >>> 22;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] filter_sample(
      logic signed [SAMPLE_W-1:0] s);
    longint x, d1, d2, w, acc, y;
    int unsigned n;
    x = s;
    n = filt_count < 1 ? 1 : (filt_count > MAX_SECTIONS ? MAX_SECTIONS : filt_count);
    for (int k = 0; k < n; k++) begin
      d1 = filt_delay[2*k];
      d2 = filt_delay[2*k+1];
      w = round_q22((x <<< 22) - filt_a1 * d1 - filt_a2 * d2);
      w = clamp(w, -64'sd2147483648, 64'sd2147483647);
      acc = round_q22(filt_b0 * w + filt_b1 * d1 + filt_b2 * d2);
      y = round_q22(acc * filt_gain);
      filt_delay[2*k+1] = d1;
      filt_delay[2*k] = w;
      x = clamp(y, -64'sd8388608, 64'sd8388607);
    end
    return x[SAMPLE_W-1:0];
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [COEF_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_B0: filt_b0 = longint'(signed'(val));
      CFG_B1: filt_b1 = longint'(signed'(val));
      CFG_B2: filt_b2 = longint'(signed'(val));
      CFG_A1: filt_a1 = longint'(signed'(val));
      CFG_A2: filt_a2 = longint'(signed'(val));
      CFG_GAIN: filt_gain = val[GAIN_W-1:0];
      CFG_COUNT: filt_count = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_filter(int b0, int b1, int b2, int a1, int a2, int gain, int cnt);
    write_reg(CFG_B0, b0[COEF_W-1:0]);
    write_reg(CFG_B1, b1[COEF_W-1:0]);
    write_reg(CFG_B2, b2[COEF_W-1:0]);
    write_reg(CFG_A1, a1[COEF_W-1:0]);
    write_reg(CFG_A2, a2[COEF_W-1:0]);
    write_reg(CFG_GAIN, gain[COEF_W-1:0]);
    write_reg(CFG_COUNT, cnt[COEF_W-1:0]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    expected_samples.push_back(filter_sample(s));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic test_reset_state();
    send_sample(24'sh7FFFFF);
    send_sample(-24'sh800000);
    send_sample(24'sh000001);
    wait_drained();
  endtask

  task automatic test_directed_extremes();
    load_filter(4194304, 0, 0, 0, 0, 4194304, 0);
    send_sample(24'sh123456);
    send_sample(-24'sh800000);
    wait_drained();
    load_filter(8388607, 8388607, 8388607, -8388608, -8388608, 4194304, 3);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? -24'sh800000 : 24'sh7FFFFF);
    wait_drained();
    load_filter(-8388608, -8388608, -8388608, 8388607, 8388607, 0, 2);
    send_sample(24'sh7FFFFF);
    send_sample(24'sh555555);
    wait_drained();
    load_filter(2097152, 4194304, 2097152, -3000000, 1500000, 8388607, 3);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 24'sh2AAAAA : -24'sh155555);
    wait_drained();
    write_reg(CFG_NONE, 24'hFFFFFF);
    send_sample(24'sh400000);
    wait_drained();
  endtask

  task automatic test_random_filters(int phases, int items_per_phase);
    for (int p = 0; p < phases; p++) begin
      if ($urandom_range(0, 1)) begin
        load_filter(1048576 + $urandom_range(0, 1048576), 2097152, 1048576,
                    -$urandom_range(2000000, 6000000), $urandom_range(500000, 3500000),
                    $urandom_range(0, 4194304), $urandom_range(0, 3));
      end else begin
        load_filter($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom_range(0, 8388607), $urandom_range(0, 3));
      end
      for (int i = 0; i < items_per_phase; i++) send_sample(rand_sample());
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("sample_out: no item expected, actual %0d", out_sample_out);
          fail_count++;
        end else begin
          if (out_sample_out !== expected_samples[0]) begin
            $error("sample_out: expected %0d, actual %0d", expected_samples[0], out_sample_out);
            fail_count++;
          end
          void'(expected_samples.pop_front());
        end
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_left <= $urandom_range(0, 18);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("** biquad_cascade_filter_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_sample_in = '0;
    out_ready = 1'b0;
    stall_left = 0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    idle_cycles = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    filt_b0 = 0; filt_b1 = 0; filt_b2 = 0; filt_a1 = 0; filt_a2 = 0;
    filt_gain = 4194304;
    filt_count = 1;
    foreach (filt_delay[i]) filt_delay[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_directed_extremes();
    test_random_filters(10, 30);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random_filters(3, 30);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** biquad_cascade_filter_core: PASSED **");
    end else begin
      $display("** biquad_cascade_filter_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/bqc_pkg.sv
rtl/bqc_mul.sv
rtl/biquad_cascade_filter_core.sv
rtl/bqc_checker.sv
tb/biquad_cascade_filter_core_tb.sv
